// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Without SYNTH they expand to concurrent
// assertions; with SYNTH they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, a, b)
`define ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

// ===== hw/rtl/rau_pkg.sv =====
`default_nettype none
package rau_pkg;

  localparam int WIDTH     = 16;
  localparam int MW        = 2 * WIDTH;
  localparam int NUM_W     = MW + 1;
  localparam int DEN_W     = MW - 1;
  localparam int KW        = $clog2(MW);
  // Each binary gcd step shortens the two magnitudes by at least one bit in total.
  localparam int GCD_STEPS = 2 * MW - 1;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [WIDTH-1:0] a_num;
    logic signed [WIDTH-1:0] a_den;
    logic signed [WIDTH-1:0] b_num;
    logic signed [WIDTH-1:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] res_num;
    logic [DEN_W-1:0]        res_den;
    logic                    undefined;
  } rsp_t;

  typedef struct packed {
    logic          neg;
    logic          nzero;
    logic          undef;
    logic [MW-1:0] nmag;
    logic [MW-1:0] dmag;
  } ctx_t;

  typedef struct packed {
    logic [MW-1:0] x;
    logic [MW-1:0] y;
    logic [KW-1:0] k;
    ctx_t          ctx;
  } gcd_t;

  typedef struct packed {
    logic [MW:0]   rn;
    logic [MW:0]   rd;
    logic [MW-1:0] dn;
    logic [MW-1:0] dd;
    logic [MW-1:0] qn;
    logic [MW-1:0] qd;
    logic [MW-1:0] g;
    ctx_t          ctx;
  } div_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rational_arith_unit.sv =====
// Rational arithmetic unit: adds, subtracts, multiplies or divides two signed
// fractions and returns the result reduced to lowest terms with a positive
// denominator, or the undefined flag when the denominator comes out zero.
//
// The request channel (req_valid, req_ready, req) carries the operation and
// the four operands; the response channel (rsp_valid, rsp_ready, rsp) carries
// one reduced fraction per request, in request order.
//
// The unit is a fixed pipeline: one multiply stage, one combine stage, 63
// binary gcd stages, one stage forming the gcd, 32 restoring divide stages
// and the output register. One transaction can be taken in every cycle
// while the receiver does not stall.
//
// When the receiver stalls, the whole pipeline holds and req_ready drops,
// so nothing is lost or repeated. Reset clears every valid bit.
`default_nettype none
`include "assert_macros.svh"
module rational_arith_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire rau_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output rau_pkg::rsp_t      rsp
);
  import rau_pkg::*;

  logic en;
  logic accept;

  logic                 mul_v;
  logic [1:0]           mul_func;
  logic signed [MW-1:0] m0, m1, m2;
  logic signed [MW-1:0] m0_next, m1_next, m2_next;

  logic signed [NUM_W-1:0] n_c;
  logic signed [MW-1:0]    d_c;
  gcd_t                    g0_next;

  logic [GCD_STEPS:0] gv;
  gcd_t               gst [0:GCD_STEPS];
  gcd_t               gnx [0:GCD_STEPS-1];

  logic [MW:0] dv;
  div_t        dst [0:MW];
  div_t        dnx [0:MW-1];
  div_t        d0_next;

  rsp_t rsp_next;

  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;
  assign accept    = req_valid && req_ready;

  // Stage 0: the three products. The divide denominator reuses b_num * a_den.
  always_comb begin
    m0_next = MW'(req.a_num) * ((req.func == FUNC_MUL) ? MW'(req.b_num) : MW'(req.b_den));
    m1_next = MW'(req.b_num) * MW'(req.a_den);
    m2_next = MW'(req.a_den) * MW'(req.b_den);
  end

  // Stage 1: unreduced numerator and denominator, magnitudes and flags.
  always_comb begin
    unique case (func_t'(mul_func))
      FUNC_ADD: n_c = NUM_W'(m0) + NUM_W'(m1);
      FUNC_SUB: n_c = NUM_W'(m0) - NUM_W'(m1);
      FUNC_MUL: n_c = NUM_W'(m0);
      FUNC_DIV: n_c = NUM_W'(m0);
      default:  n_c = NUM_W'(m0);
    endcase
    d_c = (func_t'(mul_func) == FUNC_DIV) ? m1 : m2;

    g0_next.ctx.nzero = (n_c == '0);
    g0_next.ctx.undef = (d_c == '0);
    g0_next.ctx.neg   = n_c[NUM_W-1] ^ d_c[MW-1];
    g0_next.ctx.nmag  = n_c[NUM_W-1] ? MW'(-n_c) : MW'(n_c);
    g0_next.ctx.dmag  = d_c[MW-1] ? MW'(-d_c) : MW'(d_c);
    // Degenerate cases bypass the reduction, so feed the gcd something harmless.
    if (g0_next.ctx.nzero || g0_next.ctx.undef) begin
      g0_next.x = MW'(1);
      g0_next.y = MW'(1);
    end else begin
      g0_next.x = g0_next.ctx.nmag;
      g0_next.y = g0_next.ctx.dmag;
    end
    g0_next.k = '0;
  end

  for (genvar i = 0; i < GCD_STEPS; i++) begin : g_gcd
    rau_gcd_step u_step (
      .cur (gst[i]),
      .nxt (gnx[i])
    );
  end

  // One operand is zero by now, so the other holds the odd part of the gcd.
  always_comb begin
    d0_next     = '0;
    d0_next.dn  = gst[GCD_STEPS].ctx.nmag;
    d0_next.dd  = gst[GCD_STEPS].ctx.dmag;
    d0_next.g   = (gst[GCD_STEPS].x | gst[GCD_STEPS].y) << gst[GCD_STEPS].k;
    d0_next.ctx = gst[GCD_STEPS].ctx;
  end

  for (genvar j = 0; j < MW; j++) begin : g_div
    logic [MW:0] rn_sh;
    logic [MW:0] rd_sh;
    always_comb begin
      rn_sh  = {dst[j].rn[MW-1:0], dst[j].dn[MW-1]};
      rd_sh  = {dst[j].rd[MW-1:0], dst[j].dd[MW-1]};
      dnx[j] = dst[j];
      dnx[j].dn = {dst[j].dn[MW-2:0], 1'b0};
      dnx[j].dd = {dst[j].dd[MW-2:0], 1'b0};
      if (rn_sh >= {1'b0, dst[j].g}) begin
        dnx[j].rn = rn_sh - {1'b0, dst[j].g};
        dnx[j].qn = {dst[j].qn[MW-2:0], 1'b1};
      end else begin
        dnx[j].rn = rn_sh;
        dnx[j].qn = {dst[j].qn[MW-2:0], 1'b0};
      end
      if (rd_sh >= {1'b0, dst[j].g}) begin
        dnx[j].rd = rd_sh - {1'b0, dst[j].g};
        dnx[j].qd = {dst[j].qd[MW-2:0], 1'b1};
      end else begin
        dnx[j].rd = rd_sh;
        dnx[j].qd = {dst[j].qd[MW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    rsp_next.undefined = dst[MW].ctx.undef;
    if (dst[MW].ctx.undef) begin
      rsp_next.res_num = '0;
      rsp_next.res_den = '0;
    end else if (dst[MW].ctx.nzero) begin
      rsp_next.res_num = '0;
      rsp_next.res_den = DEN_W'(1);
    end else begin
      rsp_next.res_num = dst[MW].ctx.neg ? -NUM_W'(dst[MW].qn) : NUM_W'(dst[MW].qn);
      rsp_next.res_den = dst[MW].qd[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v     <= 1'b0;
      gv        <= '0;
      dv        <= '0;
      rsp_valid <= 1'b0;
    end else if (en) begin
      mul_v     <= accept;
      gv        <= {gv[GCD_STEPS-1:0], mul_v};
      dv        <= {dv[MW-1:0], gv[GCD_STEPS]};
      rsp_valid <= dv[MW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_func <= req.func;
      m0       <= m0_next;
      m1       <= m1_next;
      m2       <= m2_next;
      gst[0]   <= g0_next;
      for (int i = 0; i < GCD_STEPS; i++) begin
        gst[i+1] <= gnx[i];
      end
      dst[0] <= d0_next;
      for (int j = 0; j < MW; j++) begin
        dst[j+1] <= dnx[j];
      end
      rsp <= rsp_next;
    end
  end

  `ASSERT_IMPLY(a_undef_zero, clk, rst, rsp_valid && rsp.undefined, rsp.res_num == '0 && rsp.res_den == '0)
  `ASSERT_IMPLY(a_den_nonzero, clk, rst, rsp_valid && !rsp.undefined, rsp.res_den != '0)
  `ASSERT_IMPLY(a_zero_num, clk, rst, rsp_valid && !rsp.undefined && rsp.res_num == '0, rsp.res_den == DEN_W'(1))
  `ASSERT_IMPLY(a_stall_blocks, clk, rst, rsp_valid && !rsp_ready, !req_ready)
  `ASSERT_NEXT(a_enter, clk, rst, req_valid && req_ready, mul_v)

endmodule
`default_nettype wire

// ===== hw/rtl/rau_gcd_step.sv =====
`default_nettype none
module rau_gcd_step (
  input  wire rau_pkg::gcd_t cur,
  output rau_pkg::gcd_t      nxt
);
  import rau_pkg::*;

  always_comb begin
    nxt = cur;
    if (cur.x == '0 || cur.y == '0) begin
      nxt = cur;
    end else if (!cur.x[0] && !cur.y[0]) begin
      nxt.x = cur.x >> 1;
      nxt.y = cur.y >> 1;
      nxt.k = cur.k + KW'(1);
    end else if (!cur.x[0]) begin
      nxt.x = cur.x >> 1;
    end else if (!cur.y[0]) begin
      nxt.y = cur.y >> 1;
    end else if (cur.x >= cur.y) begin
      // Both odd: the difference is even, so halve it in the same step.
      nxt.x = (cur.x - cur.y) >> 1;
    end else begin
      nxt.y = (cur.y - cur.x) >> 1;
    end
  end

endmodule
`default_nettype wire
